### hdl/scp_pkg.sv
// scp_pkg: shared types, character codes, parser state codes and hex helpers
// for the serial command parser; no dependencies
`default_nettype none

package scp_pkg;

    // default sizes
    localparam int DEF_BUFFER_DEPTH       = 32;
    localparam int DEF_NAME_MAX_LEN       = 16;
    localparam int DEF_STATE_TEXT_MAX_LEN = 5;
    localparam int MAX_RESULTS            = 16;

    // character codes
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CMD_DEBUG  = 8'h64; // d
    localparam logic [7:0] CMD_STATE  = 8'h73; // s
    localparam logic [7:0] CMD_CUSTOM = 8'h63; // c
    localparam logic [7:0] CMD_NAME   = 8'h6E; // n
    localparam logic [7:0] CMD_EXPIRY = 8'h65; // e
    localparam logic [7:0] CMD_PAGES  = 8'h70; // p
    localparam logic [7:0] CMD_PTIME  = 8'h74; // t
    localparam logic [7:0] CMD_MODE   = 8'h6D; // m

    // parser state, upper nibble
    localparam logic [3:0] NIB_READY  = 4'h0;
    localparam logic [3:0] NIB_CMD    = 4'h1;
    localparam logic [3:0] NIB_PAGES  = 4'h2;
    localparam logic [3:0] NIB_PTIME  = 4'h3;
    localparam logic [3:0] NIB_SSTATE = 4'h4;
    localparam logic [3:0] NIB_STEXT  = 4'h5;
    localparam logic [3:0] NIB_EXPIRY = 4'h6;
    localparam logic [3:0] NIB_NAME   = 4'h7;
    localparam logic [3:0] NIB_DEBUG  = 4'h8;
    localparam logic [3:0] NIB_MODE   = 4'h9;
    localparam logic [3:0] NIB_CLEAR  = 4'hF;

    // event kinds
    localparam logic [2:0] K_PAGES  = 3'd0;
    localparam logic [2:0] K_PTIME  = 3'd1;
    localparam logic [2:0] K_MODE   = 3'd2;
    localparam logic [2:0] K_EXPIRY = 3'd3;
    localparam logic [2:0] K_STATE  = 3'd4;
    localparam logic [2:0] K_STEXT  = 3'd5;
    localparam logic [2:0] K_NAME   = 3'd6;
    localparam logic [2:0] K_DEBUG  = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  svc;
        logic [15:0] val;
        logic [7:0]  ch;
        logic        cv;
        logic        dbg;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_TAKE, S_PUSH2, S_DISP, S_RDW, S_HDR, S_CMD, S_HXR,
        S_HXD, S_HXE, S_TXCHK, S_TXR, S_TXD, S_EMIT, S_CHECK, S_FLUSH
    } t_seq;

    // {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                return {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                return {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

    // two-character hex value, stopping at the first non-hex char
    function automatic logic [7:0] hex2(input logic [7:0] c0, input logic [7:0] c1);
        logic [4:0] h0;
        logic [4:0] h1;
        begin
            h0 = hex_digit(c0);
            h1 = hex_digit(c1);
            if (!h0[4]) return 8'h00;
            if (!h1[4]) return {4'h0, h0[3:0]};
            return {h0[3:0], h1[3:0]};
        end
    endfunction

endpackage

`default_nettype wire

### hdl/scp_ram.sv
// scp_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module scp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/serial_command_parser_unit.sv
// serial_command_parser_unit: top level of the serial command parser
// depends on scp_pkg and scp_ram
`default_nettype none

// channel  | handshake                 | payload
// rx in    | i_rx_valid / o_rx_ready   | i_rx_byte
// event out| o_ev_valid / i_ev_ready   | o_event_kind .. o_debug_enabled, o_last
//
// intake passes through idle and take, plus a second push after an escape;
// each handler pass then reads the buffer ram once per buffer char and reads
// hex digits one at a time through a read and a decode state, and a text run
// goes through read, data and emit states per char, using the collect buffer
// read port; a byte ends with a flush step
// reset: synchronous, active low; clears parser state, lengths, flags, queues
// output stalls hold the sequencer whenever a staged result must move on, in emit or flush

module serial_command_parser_unit
    import scp_pkg::t_result;
#(
    parameter int BUFFER_DEPTH       = scp_pkg::DEF_BUFFER_DEPTH,
    parameter int NAME_MAX_LEN       = scp_pkg::DEF_NAME_MAX_LEN,
    parameter int STATE_TEXT_MAX_LEN = scp_pkg::DEF_STATE_TEXT_MAX_LEN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_ev_valid,
    input  wire logic        i_ev_ready,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_service_id,
    output logic [15:0]      o_value,
    output logic [7:0]       o_text_char,
    output logic             o_char_valid,
    output logic             o_last,
    output logic             o_debug_enabled
);
    import scp_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int LW = $clog2(BUFFER_DEPTH + 1);

    // sequencer and parser state
    t_seq            r_st, n_st, r_after, n_after, r_ret, n_ret;
    logic [7:0]      r_ps, n_ps, r_ps0, n_ps0;
    logic [LW-1:0]   r_len, n_len, r_len0, n_len0;
    logic [AW-1:0]   r_idx, n_idx, r_hlast, n_hlast, r_n, n_n;
    logic [15:0]     r_acc, n_acc;
    logic [7:0]      r_byte, n_byte, r_svc, n_svc;
    logic [7:0]      r_esc0, n_esc0, r_esc1, n_esc1;
    logic [1:0]      r_esc_cnt, n_esc_cnt;
    logic            r_esc_act, n_esc_act, r_dbg, n_dbg;
    // result path: one staged result, then the output register
    t_result         r_em, n_em, r_pend, n_pend, r_out, n_out;
    logic            r_pv, n_pv, r_ov, n_ov, r_olast, n_olast;
    logic [4:0]      r_cnt, n_cnt;

    // buffer ram
    logic            push_en;
    logic [7:0]      push_data;
    logic            ram_we;
    logic [7:0]      ram_rd;

    logic [3:0]      nib, sub;
    logic [4:0]      hd;
    logic            out_free;
    logic [2:0]      txt_kind;
    logic            txt_end;

    assign nib      = r_ps[7:4];
    assign sub      = r_ps[3:0];
    assign out_free = !r_ov || i_ev_ready;
    assign txt_kind = (nib == NIB_STEXT) ? K_STEXT : K_NAME;
    assign hd       = hex_digit(ram_rd);
    assign txt_end  = (ram_rd == CHAR_BANG) ||
        ((nib == NIB_STEXT) ? (32'(r_idx) == STATE_TEXT_MAX_LEN)
                            : (32'(r_idx) == NAME_MAX_LEN));

    scp_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (push_data),
        .i_raddr (r_idx),
        .o_rdata (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_ps      <= {NIB_READY, 4'h0};
            r_len     <= '0;
            r_esc_cnt <= '0;
            r_esc_act <= 1'b0;
            r_svc     <= '0;
            r_dbg     <= 1'b0;
            r_pv      <= 1'b0;
            r_ov      <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_st      <= n_st;
            r_ps      <= n_ps;
            r_len     <= n_len;
            r_esc_cnt <= n_esc_cnt;
            r_esc_act <= n_esc_act;
            r_svc     <= n_svc;
            r_dbg     <= n_dbg;
            r_pv      <= n_pv;
            r_ov      <= n_ov;
            r_cnt     <= n_cnt;
        end
        r_after <= n_after;
        r_ret   <= n_ret;
        r_ps0   <= n_ps0;
        r_len0  <= n_len0;
        r_idx   <= n_idx;
        r_hlast <= n_hlast;
        r_n     <= n_n;
        r_acc   <= n_acc;
        r_byte  <= n_byte;
        r_esc0  <= n_esc0;
        r_esc1  <= n_esc1;
        r_em    <= n_em;
        r_pend  <= n_pend;
        r_out   <= n_out;
        r_olast <= n_olast;
    end

    always_comb begin
        n_st = r_st; n_after = r_after; n_ret = r_ret;
        n_ps = r_ps; n_ps0 = r_ps0; n_len = r_len; n_len0 = r_len0;
        n_idx = r_idx; n_hlast = r_hlast; n_n = r_n; n_acc = r_acc;
        n_byte = r_byte; n_svc = r_svc; n_esc0 = r_esc0; n_esc1 = r_esc1;
        n_esc_cnt = r_esc_cnt; n_esc_act = r_esc_act; n_dbg = r_dbg;
        n_em = r_em; n_pend = r_pend; n_pv = r_pv; n_cnt = r_cnt;
        n_out = r_out; n_olast = r_olast;
        n_ov = r_ov && !i_ev_ready;
        push_en = 1'b0;
        push_data = r_byte;

        unique case (r_st)
            S_IDLE: begin
                if (i_rx_valid) begin
                    n_byte = i_rx_byte;
                    n_cnt  = '0;
                    n_st   = S_TAKE;
                end
            end
            S_TAKE: begin
                n_st = S_DISP;
                if (r_byte == CHAR_CR || r_byte == CHAR_LF) begin
                    n_len = '0;
                end else if (!r_esc_act) begin
                    if (r_byte == CHAR_BSL) begin
                        n_esc_cnt = '0;
                        n_esc_act = 1'b1;
                    end else begin
                        push_en = 1'b1;
                    end
                end else if (r_byte == CHAR_BSL) begin
                    push_en   = 1'b1;
                    n_esc_act = 1'b0;
                end else if (r_esc_cnt < 2'd2) begin
                    if (r_esc_cnt == 2'd0) n_esc0 = r_byte;
                    else n_esc1 = r_byte;
                    n_esc_cnt = r_esc_cnt + 2'd1;
                end else begin
                    // escaped byte first, then the char that ended the escape
                    push_en   = 1'b1;
                    push_data = hex2(r_esc0, r_esc1);
                    n_esc_act = 1'b0;
                    n_st      = S_PUSH2;
                end
            end
            S_PUSH2: begin
                push_en = 1'b1;
                n_st    = S_DISP;
            end
            S_DISP: begin
                n_ps0  = r_ps;
                n_len0 = r_len;
                n_st   = S_CHECK;
                n_acc  = '0;
                unique case (nib)
                    NIB_READY: begin
                        if (sub > 4'd1) begin
                            n_ps = {NIB_READY, 4'h0};
                        end else if (r_len > LW'(sub)) begin
                            n_idx   = AW'(sub);
                            n_after = S_HDR;
                            n_st    = S_RDW;
                        end
                    end
                    NIB_CMD: begin
                        if (r_len != '0) begin
                            n_idx   = '0;
                            n_after = S_CMD;
                            n_st    = S_RDW;
                        end
                    end
                    NIB_PAGES, NIB_PTIME, NIB_MODE: begin
                        if (r_len >= LW'(2)) begin
                            n_idx = '0; n_hlast = AW'(1); n_st = S_HXR;
                        end
                    end
                    NIB_EXPIRY: begin
                        if (r_len >= LW'(4)) begin
                            n_idx = '0; n_hlast = AW'(3); n_st = S_HXR;
                        end
                    end
                    NIB_SSTATE, NIB_STEXT, NIB_NAME: begin
                        if (sub == 4'd0 || (sub == 4'd1 && nib != NIB_NAME)) begin
                            if (r_len >= LW'(2)) begin
                                n_idx = '0; n_hlast = AW'(1); n_st = S_HXR;
                            end
                        end else if (nib == NIB_NAME || (sub == 4'd2 && nib == NIB_STEXT))
                        begin
                            if (r_len != '0) begin
                                n_idx   = AW'(r_len - LW'(1));
                                n_after = S_TXCHK;
                                n_st    = S_RDW;
                            end
                        end else begin
                            n_ps = {NIB_CLEAR, 4'h0};
                        end
                    end
                    NIB_DEBUG: begin
                        n_dbg = !r_dbg;
                        n_em  = '{kind: K_DEBUG, svc: 8'h00, val: 16'h0000,
                                  ch: 8'h00, cv: 1'b0, dbg: !r_dbg};
                        n_ps  = {NIB_CLEAR, 4'h0};
                        n_ret = S_CHECK;
                        n_st  = S_EMIT;
                    end
                    default: begin
                        n_len     = '0;
                        n_esc_cnt = '0;
                        n_esc_act = 1'b0;
                        n_svc     = '0;
                        n_ps      = {NIB_READY, 4'h0};
                    end
                endcase
            end
            S_RDW: n_st = r_after;
            S_HDR: begin
                n_st = S_CHECK;
                if (ram_rd != ((sub != 4'd0) ? CHAR_COLON : CHAR_AT)) begin
                    n_len = '0;
                end else if (sub == 4'd1) begin
                    n_ps  = {NIB_CMD, 4'h0};
                    n_len = '0;
                end else begin
                    n_ps = r_ps + 8'd1;
                end
            end
            S_CMD: begin
                n_len = '0;
                n_st  = S_CHECK;
                priority case (ram_rd)
                    CMD_DEBUG:  n_ps = {NIB_DEBUG, 4'h0};
                    CMD_STATE:  n_ps = {NIB_SSTATE, 4'h0};
                    CMD_CUSTOM: n_ps = {NIB_STEXT, 4'h0};
                    CMD_NAME:   n_ps = {NIB_NAME, 4'h0};
                    CMD_EXPIRY: n_ps = {NIB_EXPIRY, 4'h0};
                    CMD_PAGES:  n_ps = {NIB_PAGES, 4'h0};
                    CMD_PTIME:  n_ps = {NIB_PTIME, 4'h0};
                    CMD_MODE:   n_ps = {NIB_MODE, 4'h0};
                    default:    n_ps = {NIB_CLEAR, 4'h0};
                endcase
            end
            S_HXR: n_st = S_HXD;
            S_HXD: begin
                if (!hd[4]) begin
                    n_st = S_HXE;
                end else begin
                    n_acc = {r_acc[11:0], hd[3:0]};
                    if (r_idx == r_hlast) begin
                        n_st = S_HXE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                        n_st  = S_HXR;
                    end
                end
            end
            S_HXE: begin
                n_st  = S_CHECK;
                n_ret = S_CHECK;
                n_em  = '{kind: K_PAGES, svc: 8'h00, val: r_acc,
                          ch: 8'h00, cv: 1'b0, dbg: 1'b0};
                unique case (nib)
                    NIB_PAGES, NIB_PTIME, NIB_MODE, NIB_EXPIRY: begin
                        priority case (nib)
                            NIB_PTIME:  n_em.kind = K_PTIME;
                            NIB_MODE:   n_em.kind = K_MODE;
                            NIB_EXPIRY: n_em.kind = K_EXPIRY;
                            default:    n_em.kind = K_PAGES;
                        endcase
                        n_ps = {NIB_CLEAR, 4'h0};
                        n_st = S_EMIT;
                    end
                    NIB_SSTATE, NIB_STEXT, NIB_NAME: begin
                        if (sub == 4'd0) begin
                            n_svc = r_acc[7:0];
                            n_len = '0;
                            n_ps  = r_ps + 8'd1;
                        end else begin
                            n_em.kind = K_STATE;
                            n_em.svc  = r_svc;
                            if (nib == NIB_STEXT) begin
                                n_len = '0;
                                n_ps  = r_ps + 8'd1;
                            end else begin
                                n_ps = {NIB_CLEAR, 4'h0};
                            end
                            n_st = S_EMIT;
                        end
                    end
                    default: n_st = S_CHECK;
                endcase
            end
            S_TXCHK: begin
                n_st = S_CHECK;
                if (txt_end) begin
                    if (r_idx == '0) begin
                        // empty run still reports once
                        n_em  = '{kind: txt_kind, svc: r_svc, val: 16'h0000,
                                  ch: 8'h00, cv: 1'b0, dbg: 1'b0};
                        n_ps  = {NIB_CLEAR, 4'h0};
                        n_ret = S_CHECK;
                        n_st  = S_EMIT;
                    end else begin
                        n_n   = r_idx;
                        n_idx = '0;
                        n_st  = S_TXR;
                    end
                end
            end
            S_TXR: begin
                if (r_idx == r_n) begin
                    n_ps = {NIB_CLEAR, 4'h0};
                    n_st = S_CHECK;
                end else begin
                    n_st = S_TXD;
                end
            end
            S_TXD: begin
                n_em  = '{kind: txt_kind, svc: r_svc, val: 16'h0000,
                          ch: ram_rd, cv: 1'b1, dbg: 1'b0};
                n_idx = r_idx + AW'(1);
                n_ret = S_TXR;
                n_st  = S_EMIT;
            end
            S_EMIT: begin
                if (r_cnt == 5'(MAX_RESULTS)) begin
                    n_st = r_ret;
                end else if (!r_pv) begin
                    n_pend = r_em;
                    n_pv   = 1'b1;
                    n_cnt  = r_cnt + 5'd1;
                    n_st   = r_ret;
                end else if (out_free) begin
                    n_out   = r_pend;
                    n_olast = 1'b0;
                    n_ov    = 1'b1;
                    n_pend  = r_em;
                    n_cnt   = r_cnt + 5'd1;
                    n_st    = r_ret;
                end
            end
            S_CHECK: begin
                if (r_ps == r_ps0 && r_len == r_len0) n_st = S_FLUSH;
                else n_st = S_DISP;
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_st = S_IDLE;
                end else if (out_free) begin
                    n_out   = r_pend;
                    n_olast = 1'b1;
                    n_ov    = 1'b1;
                    n_pv    = 1'b0;
                    n_st    = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase

        // buffer push; a full buffer drops the byte
        ram_we = push_en && (r_len < LW'(BUFFER_DEPTH));
        if (ram_we) n_len = r_len + LW'(1);
    end

    assign o_rx_ready      = (r_st == S_IDLE);
    assign o_ev_valid      = r_ov;
    assign o_event_kind    = r_out.kind;
    assign o_service_id    = r_out.svc;
    assign o_value         = r_out.val;
    assign o_text_char     = r_out.ch;
    assign o_char_valid    = r_out.cv;
    assign o_debug_enabled = r_out.dbg;
    assign o_last          = r_olast;

    // fill level never passes the buffer depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(BUFFER_DEPTH)) else $error("collect length overflow");

    // no staged result left over when a new byte may enter
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_ready |-> !r_pv) else $error("staged result left at idle");

    // results per byte capped
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'(MAX_RESULTS)) else $error("result count overflow");

    // escape digit count stays within two
    a_esc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_cnt != 2'd3) else $error("escape count overflow");

endmodule

`default_nettype wire

### dv/serial_command_parser_unit_tb.sv
// serial_command_parser_unit_tb: self-checking bench for the serial command parser
// depends on scp_pkg and the serial_command_parser_unit rtl
`timescale 1ns / 100ps

module serial_command_parser_unit_tb;
    import scp_pkg::*;

    localparam int BUF_DEPTH = DEF_BUFFER_DEPTH;
    localparam int NAME_LEN  = DEF_NAME_MAX_LEN;
    localparam int STEXT_LEN = DEF_STATE_TEXT_MAX_LEN;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  svc;
        logic [15:0] val;
        logic [7:0]  ch;
        logic        cv;
        logic        lst;
        logic        dbg;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ev_ready = 1'b0;
    logic        o_rx_ready;
    logic        o_ev_valid;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_service_id;
    logic [15:0] o_value;
    logic [7:0]  o_text_char;
    logic        o_char_valid;
    logic        o_last;
    logic        o_debug_enabled;

    // idle chance in percent for each side
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned fail_count = 0;

    // predicted event words, oldest first
    t_event expected_events[$];

    // parser model state
    logic [7:0] m_state;
    logic [7:0] m_buf [BUF_DEPTH];
    int         m_len;
    logic [7:0] m_esc [2];
    int         m_esc_cnt;
    logic       m_esc_on;
    logic [7:0] m_svc;
    logic       m_dbg;
    int         m_nres;
    t_event     m_res [MAX_RESULTS];

    always #6 i_clk = ~i_clk;

    serial_command_parser_unit dut (.*);

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    function automatic int hexval(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [15:0] hex_at(input logic [7:0] c0, c1, c2, c3, input int n);
        logic [7:0]  cs [4];
        logic [15:0] acc;
        int d;
        cs[0] = c0; cs[1] = c1; cs[2] = c2; cs[3] = c3;
        acc = '0;
        for (int i = 0; i < n; i++) begin
            d = hexval(cs[i]);
            if (d < 0) break;
            acc = {acc[11:0], d[3:0]};
        end
        return acc;
    endfunction

    function automatic logic [15:0] buf_hex(input int n);
        return hex_at(m_buf[0], m_buf[1], m_buf[2], m_buf[3], n);
    endfunction

    function automatic void add_event(input logic [2:0] k, input logic [7:0] s,
                                      input logic [15:0] v, input logic [7:0] c,
                                      input logic cv, input logic d);
        if (m_nres >= MAX_RESULTS) return;
        m_res[m_nres] = '{kind: k, svc: s, val: v, ch: c, cv: cv, lst: 1'b0, dbg: d};
        m_nres++;
    endfunction

    function automatic void model_push(input logic [7:0] c);
        if (m_len < BUF_DEPTH) begin
            m_buf[m_len] = c;
            m_len++;
        end
    endfunction

    function automatic void model_clear();
        m_len = 0; m_esc_cnt = 0; m_esc_on = 1'b0; m_svc = '0;
        m_state = {NIB_READY, 4'h0};
    endfunction

    function automatic int text_end(input int maxlen);
        int lp;
        if (m_len == 0) return -1;
        lp = m_len - 1;
        if (lp == maxlen || m_buf[lp] == CHAR_BANG) return lp;
        return -1;
    endfunction

    function automatic void emit_run(input logic [2:0] k, input int n);
        if (n <= 0) add_event(k, m_svc, '0, '0, 1'b0, 1'b0);
        else for (int i = 0; i < n; i++) add_event(k, m_svc, '0, m_buf[i], 1'b1, 1'b0);
    endfunction

    function automatic void value_step(input logic [2:0] k, input int digits);
        if (m_len < digits) return;
        add_event(k, '0, buf_hex(digits), '0, 1'b0, 1'b0);
        m_state = {NIB_CLEAR, 4'h0};
    endfunction

    // one handler pass on the current parser state
    function automatic void handler_pass();
        logic [3:0] sub;
        logic [3:0] nib;
        logic [7:0] c;
        int n;
        sub = m_state[3:0];
        nib = m_state[7:4];
        case (nib)
            NIB_READY: begin
                if (sub > 1) m_state = {NIB_READY, 4'h0};
                else if (m_len >= sub + 1) begin
                    if (m_buf[sub] != (sub != 0 ? CHAR_COLON : CHAR_AT)) m_len = 0;
                    else if (sub == 1) begin
                        m_state = {NIB_CMD, 4'h0};
                        m_len = 0;
                    end else m_state++;
                end
            end
            NIB_CMD: begin
                if (m_len >= 1) begin
                    c = m_buf[0];
                    m_len = 0;
                    case (c)
                        CMD_DEBUG:  m_state = {NIB_DEBUG, 4'h0};
                        CMD_STATE:  m_state = {NIB_SSTATE, 4'h0};
                        CMD_CUSTOM: m_state = {NIB_STEXT, 4'h0};
                        CMD_NAME:   m_state = {NIB_NAME, 4'h0};
                        CMD_EXPIRY: m_state = {NIB_EXPIRY, 4'h0};
                        CMD_PAGES:  m_state = {NIB_PAGES, 4'h0};
                        CMD_PTIME:  m_state = {NIB_PTIME, 4'h0};
                        CMD_MODE:   m_state = {NIB_MODE, 4'h0};
                        default:    m_state = {NIB_CLEAR, 4'h0};
                    endcase
                end
            end
            NIB_PAGES:  value_step(K_PAGES, 2);
            NIB_PTIME:  value_step(K_PTIME, 2);
            NIB_MODE:   value_step(K_MODE, 2);
            NIB_EXPIRY: value_step(K_EXPIRY, 4);
            NIB_SSTATE, NIB_STEXT: begin
                if (sub == 0) begin
                    if (m_len >= 2) begin
                        m_svc = 8'(buf_hex(2));
                        m_len = 0;
                        m_state++;
                    end
                end else if (sub == 1) begin
                    if (m_len >= 2) begin
                        add_event(K_STATE, m_svc, buf_hex(2), '0, 1'b0, 1'b0);
                        if (nib == NIB_STEXT) begin
                            m_len = 0;
                            m_state++;
                        end else m_state = {NIB_CLEAR, 4'h0};
                    end
                end else if (sub == 2 && nib == NIB_STEXT) begin
                    n = text_end(STEXT_LEN);
                    if (n >= 0) begin
                        emit_run(K_STEXT, n);
                        m_state = {NIB_CLEAR, 4'h0};
                    end
                end else m_state = {NIB_CLEAR, 4'h0};
            end
            NIB_NAME: begin
                if (sub == 0) begin
                    if (m_len >= 2) begin
                        m_svc = 8'(buf_hex(2));
                        m_len = 0;
                        m_state++;
                    end
                end else begin
                    n = text_end(NAME_LEN);
                    if (n >= 0) begin
                        emit_run(K_NAME, n);
                        m_state = {NIB_CLEAR, 4'h0};
                    end
                end
            end
            NIB_DEBUG: begin
                m_dbg = ~m_dbg;
                add_event(K_DEBUG, '0, '0, '0, 1'b0, m_dbg);
                m_state = {NIB_CLEAR, 4'h0};
            end
            default: model_clear();
        endcase
    endfunction

    // predicts the events one received byte causes and queues them
    function automatic void predict_events(input logic [7:0] c);
        logic [7:0] ps;
        int ln;
        m_nres = 0;
        if (c == CHAR_CR || c == CHAR_LF) m_len = 0;
        else if (!m_esc_on) begin
            if (c == CHAR_BSL) begin
                m_esc_cnt = 0;
                m_esc_on = 1'b1;
            end else model_push(c);
        end else if (c == CHAR_BSL) begin
            model_push(c);
            m_esc_on = 1'b0;
        end else if (m_esc_cnt < 2) begin
            m_esc[m_esc_cnt] = c;
            m_esc_cnt++;
        end else begin
            model_push(8'(hex_at(m_esc[0], m_esc[1], 8'h00, 8'h00, 2)));
            model_push(c);
            m_esc_on = 1'b0;
        end
        for (int g = 0; g < 64; g++) begin
            ps = m_state;
            ln = m_len;
            handler_pass();
            if (ps == m_state && ln == m_len) break;
        end
        if (m_nres > 0) m_res[m_nres-1].lst = 1'b1;
        for (int i = 0; i < m_nres; i++) expected_events.push_back(m_res[i]);
    endfunction

    // sends one byte, with random idle gaps before it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_events(b);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
    endtask

    // sender goes quiet after its last word
    task automatic send_idle();
        i_rx_valid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (i_rst_n) i_ev_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // checks each accepted event word against the oldest prediction
    always @(posedge i_clk) begin
        t_event exp_ev;
        if (i_rst_n && o_ev_valid && i_ev_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("event word with nothing expected");
            end else begin
                exp_ev = expected_events.pop_front();
                if (o_event_kind !== exp_ev.kind || o_service_id !== exp_ev.svc ||
                    o_value !== exp_ev.val || o_text_char !== exp_ev.ch ||
                    o_char_valid !== exp_ev.cv || o_last !== exp_ev.lst ||
                    o_debug_enabled !== exp_ev.dbg)
                    report_mismatch($sformatf(
                        "got k%0d s%h v%h c%h cv%b l%b d%b exp k%0d s%h v%h c%h cv%b l%b d%b",
                        o_event_kind, o_service_id, o_value, o_text_char, o_char_valid,
                        o_last, o_debug_enabled, exp_ev.kind, exp_ev.svc, exp_ev.val,
                        exp_ev.ch, exp_ev.cv, exp_ev.lst, exp_ev.dbg));
            end
        end
    end

    task automatic wait_drained();
        send_idle();
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // every command, escapes, header mismatch, clears and the state text limit
    task automatic test_directed();
        send_text("@:p7F@:tA@:mff");
        send_text("@:e1234@:d@:d");
        send_text("@:s0a3c@:c05q1hi!");
        send_text("@:n2Zab!");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("@@:x@:c01q2123456");
        send_text("@:\\4");
        send_text("1Z\\\\p\r");
        send_byte(CHAR_LF);
        wait_drained();
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] h [22] = '{"0","1","2","3","4","5","6","7","8","9",
                               "a","b","c","d","e","f","A","B","C","D","E","F"};
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return h[$urandom_range(21)];
    endfunction

    function automatic logic [7:0] rand_text_char();
        if ($urandom_range(7) == 0) return CHAR_BANG;
        return 8'($urandom_range(255));
    endfunction

    // mostly well formed commands with random content, some noise
    task automatic test_random(input int n_items);
        int sent;
        logic [7:0] cmds [8] = '{CMD_DEBUG, CMD_STATE, CMD_CUSTOM, CMD_NAME,
                                CMD_EXPIRY, CMD_PAGES, CMD_PTIME, CMD_MODE};
        logic [7:0] cmd;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 2) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else begin
                send_text("@:");
                cmd = ($urandom_range(15) == 0) ? 8'($urandom_range(255))
                                                : cmds[$urandom_range(7)];
                send_byte(cmd);
                sent += 3;
                if (cmd != CMD_DEBUG) begin
                    for (int i = 0; i < 4; i++) send_byte(rand_hex_char());
                    sent += 4;
                    if (cmd == CMD_CUSTOM || cmd == CMD_NAME) begin
                        for (int i = 0; i < 18 && expected_events.size() < 40; i++) begin
                            send_byte(($urandom_range(19) == 0) ? CHAR_BSL : rand_text_char());
                            sent++;
                        end
                        send_byte(CHAR_BANG);
                        sent++;
                    end
                end
            end
        end
    endtask

    // sender holds off until all outstanding events are back
    task automatic test_pause();
        send_text("@:c3F01xy");
        send_idle();
        while (expected_events.size() != 0) @(posedge i_clk);
        send_text("z!@:d");
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        tx_idle_pct = 0;  rx_stall_pct = 0;  test_random(25);
        tx_idle_pct = 49; rx_stall_pct = 0;  test_random(25);
        test_pause();
        tx_idle_pct = 0;  rx_stall_pct = 49; test_random(25);
        tx_idle_pct = 29; rx_stall_pct = 29; test_random(25);
        wait_drained();
        if (fail_count == 0 && expected_events.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        model_clear();
        m_dbg = 1'b0;
        for (int i = 0; i < BUF_DEPTH; i++) m_buf[i] = '0;
        m_esc[0] = '0;
        m_esc[1] = '0;
    end

endmodule
